// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define SDCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that an expression never holds.
`define SDCD_ASSERT_NEVER(lbl, expr, msg) \
  `SDCD_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/core/sdcd_pkg.sv =====
package sdcd_pkg;

  localparam int unsigned CLK_W = 30;
  localparam int unsigned CODE_W = 11;
  localparam int unsigned NS_W = 24;
  localparam int unsigned DIVIDER_BITS_DEF = 11;

  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_PAD_W = OUT_DATA_W - CODE_W - CLK_W - NS_W;

  localparam logic [CLK_W-1:0] CORE_RESET_HZ = CLK_W'(250000000);
  localparam logic [CLK_W-1:0] MIN_REQ_HZ = CLK_W'(100000);
  localparam logic [CLK_W-1:0] NS_PER_SEC = CLK_W'(1000000000);
  localparam logic [NS_W-1:0] NS_MAX = '1;
  localparam int unsigned NS_SHIFT = 3;

  typedef struct packed {
    logic             valid;
    logic [CLK_W-1:0] rem;
    logic [CLK_W-1:0] quo;
    logic [CLK_W-1:0] dsr;
  } div_lane_t;

endpackage

// ===== rtl/core/sdcd_div_cell.sv =====
`include "assert_macros.svh"

module sdcd_div_cell #(
  parameter int unsigned BIT = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [sdcd_pkg::CLK_W-1:0]     dividend,
  input  sdcd_pkg::div_lane_t            lane_i,
  input  logic [SIDE_W-1:0]              side_i,
  output sdcd_pkg::div_lane_t            lane_o,
  output logic [SIDE_W-1:0]              side_o
);
  import sdcd_pkg::*;

  localparam int unsigned DBIT = CLK_W - 1 - BIT;

  div_lane_t         lane_r;
  div_lane_t         lane_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [CLK_W:0]    shifted;
  logic [CLK_W:0]    diff;
  logic              ge;

  always_comb begin
    shifted = {lane_i.rem, dividend[DBIT]};
    diff = shifted - {1'b0, lane_i.dsr};
    ge = !diff[CLK_W];
    lane_nxt.valid = lane_i.valid;
    lane_nxt.dsr = lane_i.dsr;
    lane_nxt.rem = ge ? diff[CLK_W-1:0] : shifted[CLK_W-1:0];
    lane_nxt.quo = {lane_i.quo[CLK_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r <= lane_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
    end
  end

  assign lane_o = lane_r;
  assign side_o = side_r;

  `SDCD_ASSERT(a_rem_below_dsr,
    lane_r.valid |-> (lane_r.rem < lane_r.dsr) || (lane_r.dsr == '0),
    "Partial remainder reached the divisor.")

endmodule

// ===== rtl/core/sdcd_div_chain.sv =====
module sdcd_div_chain #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [sdcd_pkg::CLK_W-1:0] dividend,
  input  sdcd_pkg::div_lane_t        lane_i,
  input  logic [SIDE_W-1:0]          side_i,
  output sdcd_pkg::div_lane_t        lane_o,
  output logic [SIDE_W-1:0]          side_o
);
  import sdcd_pkg::*;

  div_lane_t         lane [CLK_W+1];
  logic [SIDE_W-1:0] side [CLK_W+1];

  assign lane[0] = lane_i;
  assign side[0] = side_i;

  for (genvar i = 0; i < CLK_W; i++) begin : g_cell
    sdcd_div_cell #(
      .BIT(i),
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .en(en),
      .dividend(dividend),
      .lane_i(lane[i]),
      .side_i(side[i]),
      .lane_o(lane[i+1]),
      .side_o(side[i+1])
    );
  end

  assign lane_o = lane[CLK_W];
  assign side_o = side[CLK_W];

endmodule

// ===== rtl/core/sd_clock_divider_calc_top.sv =====
// Card clock divider calculation for an SD host.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the core clock in Hz;
// cfg_ready is always high and a write should only be made while no request is in flight.
// Each transfer on the in_ channel carries a requested card clock in Hz. Each produces
// exactly one transfer on the out_ channel with the divider code, the achieved clock,
// the nanoseconds per FIFO word and, in out_tuser, a flag that the timing fields are valid.
// A request below 100 kHz returns the largest code with the flag and timing fields at zero.
// The pipeline is three rows of 30 restoring-division cells (core over request,
// core over divisor, one second over achieved clock) plus two fix-up registers.
// A new request is taken every cycle unless the receiver stalls, as every cell is a
// pipeline stage of its own. When the receiver stalls with a result in the output register,
// all cells and fix-up registers hold and in_tready drops until the result is taken.
// Reset empties the pipeline and loads a 250 MHz core clock.
`include "assert_macros.svh"

module sd_clock_divider_calc_top #(
  parameter int unsigned DIVIDER_BITS = sdcd_pkg::DIVIDER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sdcd_pkg::CLK_W-1:0]      cfg_data,     // core_clock_hz
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sdcd_pkg::IN_DATA_W-1:0]  in_tdata,     // requested_clock_hz
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sdcd_pkg::OUT_DATA_W-1:0] out_tdata,    // divider_code, achieved_clock_hz, ns_per_word
  output logic [0:0]                      out_tuser     // timing_updated
);
  import sdcd_pkg::*;

  localparam logic [DIVIDER_BITS-1:0] CODE_MAX = '1;
  localparam logic [CODE_W-1:0] CODE_OUT_MAX = CODE_W'(CODE_MAX);
  localparam int unsigned SIDE2_W = DIVIDER_BITS + 1;
  localparam int unsigned SIDE3_W = SIDE2_W + CLK_W;

  logic                    en;
  logic [CLK_W-1:0]        core_r;
  logic [CLK_W-1:0]        req;

  div_lane_t               c1_in;
  div_lane_t               c1_out;
  logic [0:0]              c1_side_in;
  logic [0:0]              c1_side_out;

  logic                    b_valid_r;
  logic                    b_slow_r;
  logic [DIVIDER_BITS-1:0] b_code_r;
  logic [DIVIDER_BITS-1:0] b_code_nxt;
  logic [CLK_W:0]          adj;

  div_lane_t               c2_in;
  div_lane_t               c2_out;
  logic [SIDE2_W-1:0]      c2_side_out;

  div_lane_t               c3_in;
  div_lane_t               c3_out;
  logic [SIDE3_W-1:0]      c3_side_in;
  logic [SIDE3_W-1:0]      c3_side_out;

  logic                    d_valid_r;
  logic                    d_upd_r;
  logic [CODE_W-1:0]       d_code_r;
  logic [CLK_W-1:0]        d_ach_r;
  logic [NS_W-1:0]         d_ns_r;
  logic                    d_upd_nxt;
  logic [CODE_W-1:0]       d_code_nxt;
  logic [CLK_W-1:0]        d_ach_nxt;
  logic [NS_W-1:0]         d_ns_nxt;
  logic                    s3_slow;
  logic [DIVIDER_BITS-1:0] s3_code;
  logic [CLK_W-1:0]        s3_ach;

  assign en = !d_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_r <= CORE_RESET_HZ;
    end else if (cfg_valid) begin
      core_r <= cfg_data;
    end
  end

  assign req = in_tdata[CLK_W-1:0];

  always_comb begin
    c1_in.valid = in_tvalid;
    c1_in.rem = '0;
    c1_in.quo = '0;
    c1_in.dsr = req;
    c1_side_in = req < MIN_REQ_HZ;
  end

  sdcd_div_chain #(
    .SIDE_W(1)
  ) u_chain_div (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .dividend(core_r),
    .lane_i(c1_in),
    .side_i(c1_side_in),
    .lane_o(c1_out),
    .side_o(c1_side_out)
  );

  always_comb begin
    adj = {1'b0, c1_out.quo} - (CLK_W+1)'(2)
        + (CLK_W+1)'(c1_out.rem >= c1_out.quo);
    if (c1_side_out[0]) begin
      b_code_nxt = CODE_MAX;
    end else if (c1_out.quo < CLK_W'(2)) begin
      b_code_nxt = '0;
    end else if (adj > (CLK_W+1)'(CODE_MAX)) begin
      b_code_nxt = CODE_MAX;
    end else begin
      b_code_nxt = adj[DIVIDER_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= c1_out.valid;
      b_slow_r <= c1_side_out[0];
      b_code_r <= b_code_nxt;
    end
  end

  always_comb begin
    c2_in.valid = b_valid_r;
    c2_in.rem = '0;
    c2_in.quo = '0;
    c2_in.dsr = CLK_W'(b_code_r) + CLK_W'(2);
  end

  sdcd_div_chain #(
    .SIDE_W(SIDE2_W)
  ) u_chain_ach (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .dividend(core_r),
    .lane_i(c2_in),
    .side_i({b_slow_r, b_code_r}),
    .lane_o(c2_out),
    .side_o(c2_side_out)
  );

  always_comb begin
    c3_in.valid = c2_out.valid;
    c3_in.rem = '0;
    c3_in.quo = '0;
    c3_in.dsr = c2_out.quo;
    c3_side_in = {c2_side_out, c2_out.quo};
  end

  sdcd_div_chain #(
    .SIDE_W(SIDE3_W)
  ) u_chain_ns (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .dividend(NS_PER_SEC),
    .lane_i(c3_in),
    .side_i(c3_side_in),
    .lane_o(c3_out),
    .side_o(c3_side_out)
  );

  always_comb begin
    {s3_slow, s3_code, s3_ach} = c3_side_out;
    d_code_nxt = CODE_W'(s3_code);
    if (s3_slow) begin
      d_upd_nxt = 1'b0;
      d_ach_nxt = '0;
      d_ns_nxt = '0;
    end else begin
      d_upd_nxt = 1'b1;
      d_ach_nxt = s3_ach;
      if (s3_ach == '0) begin
        d_ns_nxt = NS_MAX;
      end else if (c3_out.quo > CLK_W'(NS_MAX >> NS_SHIFT)) begin
        d_ns_nxt = NS_MAX;
      end else begin
        d_ns_nxt = NS_W'(c3_out.quo << NS_SHIFT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= c3_out.valid;
      d_upd_r <= d_upd_nxt;
      d_code_r <= d_code_nxt;
      d_ach_r <= d_ach_nxt;
      d_ns_r <= d_ns_nxt;
    end
  end

  assign out_tvalid = d_valid_r;
  assign out_tdata = {{OUT_PAD_W{1'b0}}, d_ns_r, d_ach_r, d_code_r};
  assign out_tuser = d_upd_r;

  `SDCD_ASSERT(a_slow_code_max,
    d_valid_r && !d_upd_r |-> d_code_r == CODE_OUT_MAX,
    "Slow request did not give the largest divider code.")

  `SDCD_ASSERT(a_slow_no_timing,
    d_valid_r && !d_upd_r |-> d_ach_r == '0 && d_ns_r == '0,
    "Slow request carried timing fields.")

  `SDCD_ASSERT_NEVER(a_zero_clock_ns,
    d_valid_r && d_upd_r && d_ach_r == '0 && d_ns_r != NS_MAX,
    "Zero achieved clock without saturated word time.")

endmodule

// ===== tb/tb_sd_clock_divider_calc_top.sv =====
`timescale 1ns / 1ps

module tb_sd_clock_divider_calc_top;

  localparam int CW = sdcd_pkg::CODE_W;
  localparam int KW = sdcd_pkg::CLK_W;
  localparam int NW = sdcd_pkg::NS_W;
  localparam logic [63:0] CODE_MAX = (64'd1 << sdcd_pkg::DIVIDER_BITS_DEF) - 64'd1;
  localparam logic [KW-1:0] REQ_MAX_HZ = KW'(1000000000);
  localparam logic [KW-1:0] CORE_MIN_HZ = KW'(1000000);
  localparam logic [KW-1:0] CORE_MAX_HZ = KW'(1000000000);
  localparam int RANDOM_PHASES = 6;
  localparam int REQUESTS_PER_PHASE = 175;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [CW-1:0] code;
    logic [KW-1:0] achieved_hz;
    logic [NW-1:0] word_ns;
    logic          timing_valid;
  } divider_result_t;

  typedef enum logic {ROW_REQUEST, ROW_CORE_CLOCK} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [KW-1:0]   value;
    logic            typed;
    divider_result_t typed_result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [KW-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [sdcd_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sdcd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;

  divider_result_t pending_results[$];
  logic [KW-1:0] core_hz = sdcd_pkg::CORE_RESET_HZ;
  int mismatch_count = 0;
  bit no_idle = 1'b0;

  stim_row_t directed_rows[] = '{
    '{ROW_REQUEST, 30'd0, 1'b1, '{11'd2047, 30'd0, 24'd0, 1'b0}},
    '{ROW_REQUEST, 30'd99999, 1'b1, '{11'd2047, 30'd0, 24'd0, 1'b0}},
    '{ROW_REQUEST, 30'd100000, 1'b0, '0},
    '{ROW_REQUEST, 30'd250000000, 1'b1, '{11'd0, 30'd125000000, 24'd64, 1'b1}},
    '{ROW_REQUEST, 30'd1000000000, 1'b1, '{11'd0, 30'd125000000, 24'd64, 1'b1}},
    '{ROW_REQUEST, 30'd400000, 1'b0, '0},
    '{ROW_REQUEST, 30'd25000000, 1'b0, '0},
    '{ROW_REQUEST, 30'd50000000, 1'b0, '0},
    '{ROW_REQUEST, 30'h1FFFFFFF, 1'b0, '0},
    '{ROW_CORE_CLOCK, 30'd1000000000, 1'b0, '0},
    '{ROW_REQUEST, 30'd1000000000, 1'b1, '{11'd0, 30'd500000000, 24'd16, 1'b1}},
    '{ROW_REQUEST, 30'd100000, 1'b0, '0},
    '{ROW_REQUEST, 30'd300000000, 1'b0, '0},
    '{ROW_REQUEST, 30'd333333334, 1'b0, '0},
    '{ROW_REQUEST, 30'd99999, 1'b1, '{11'd2047, 30'd0, 24'd0, 1'b0}},
    '{ROW_CORE_CLOCK, 30'd1000000, 1'b0, '0},
    '{ROW_REQUEST, 30'd100000, 1'b0, '0},
    '{ROW_REQUEST, 30'd1000000000, 1'b1, '{11'd0, 30'd500000, 24'd16000, 1'b1}},
    '{ROW_REQUEST, 30'd700000, 1'b0, '0},
    '{ROW_REQUEST, 30'd0, 1'b1, '{11'd2047, 30'd0, 24'd0, 1'b0}}
  };

  sd_clock_divider_calc_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic divider_result_t predict_divider(input logic [KW-1:0] core,
                                                      input logic [KW-1:0] req);
    logic [63:0] core_w;
    logic [63:0] req_w;
    logic [63:0] divisor;
    logic [63:0] achieved;
    logic [63:0] word_ns;
    divider_result_t r;
    core_w = 64'(core);
    req_w = 64'(req);
    if (req_w < 64'(sdcd_pkg::MIN_REQ_HZ)) begin
      r.code = CODE_MAX[CW-1:0];
      r.achieved_hz = '0;
      r.word_ns = '0;
      r.timing_valid = 1'b0;
      return r;
    end
    divisor = core_w / req_w;
    if (divisor < 64'd2) divisor = 64'd2;
    if (core_w / divisor > req_w) divisor = divisor + 64'd1;
    divisor = divisor - 64'd2;
    if (divisor > CODE_MAX) divisor = CODE_MAX;
    achieved = core_w / (divisor + 64'd2);
    if (achieved == 64'd0) begin
      word_ns = 64'(sdcd_pkg::NS_MAX);
    end else begin
      word_ns = (64'(sdcd_pkg::NS_PER_SEC) / achieved) << sdcd_pkg::NS_SHIFT;
      if (word_ns > 64'(sdcd_pkg::NS_MAX)) word_ns = 64'(sdcd_pkg::NS_MAX);
    end
    r.code = divisor[CW-1:0];
    r.achieved_hz = achieved[KW-1:0];
    r.word_ns = word_ns[NW-1:0];
    r.timing_valid = 1'b1;
    return r;
  endfunction

  function automatic logic [KW-1:0] pick_request(input logic [KW-1:0] core);
    logic [63:0] req;
    logic [63:0] core_w;
    core_w = 64'(core);
    case ($urandom_range(0, 9))
      0: req = 64'($urandom_range(0, 99999));
      1: begin
        case ($urandom_range(0, 6))
          0: req = 64'd100000;
          1: req = 64'(REQ_MAX_HZ);
          2: req = core_w;
          3: req = core_w / 2;
          4: req = core_w / 2 + 1;
          5: req = core_w / 2049;
          default: req = core_w / 2050;
        endcase
      end
      2, 3: req = 64'($urandom_range(100000, 1000000000));
      default: req = core_w / 64'($urandom_range(2, 2200)) + 64'($urandom_range(0, 2)) - 64'd1;
    endcase
    if (req > 64'(REQ_MAX_HZ)) req = 64'(REQ_MAX_HZ);
    return req[KW-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [KW-1:0] req, input divider_result_t want);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sdcd_pkg::IN_DATA_W'(req);
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(want);
  endtask

  task automatic write_core_clock(input logic [KW-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    core_hz = value;
  endtask

  initial begin
    out_tready <= 1'b0;
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    divider_result_t got;
    divider_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.code = out_tdata[CW-1:0];
      got.achieved_hz = out_tdata[CW +: KW];
      got.word_ns = out_tdata[CW+KW +: NW];
      got.timing_valid = out_tuser[0];
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no result expected");
      end else begin
        want = pending_results.pop_front();
        if (got.code !== want.code)
          report_mismatch($sformatf("divider_code got %0d want %0d", got.code, want.code));
        if (got.achieved_hz !== want.achieved_hz)
          report_mismatch($sformatf("achieved_clock_hz got %0d want %0d",
                                    got.achieved_hz, want.achieved_hz));
        if (got.word_ns !== want.word_ns)
          report_mismatch($sformatf("ns_per_word got %0d want %0d",
                                    got.word_ns, want.word_ns));
        if (got.timing_valid !== want.timing_valid)
          report_mismatch($sformatf("timing_updated got %0d want %0d",
                                    got.timing_valid, want.timing_valid));
      end
    end
  end

  initial begin : stimulus
    logic [KW-1:0] phase_core;
    logic [KW-1:0] req;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CORE_CLOCK) begin
        write_core_clock(directed_rows[i].value);
      end else if (directed_rows[i].typed) begin
        send_request(directed_rows[i].value, directed_rows[i].typed_result);
      end else begin
        send_request(directed_rows[i].value, predict_divider(core_hz, directed_rows[i].value));
      end
    end

    // The last phase runs with both sides streaming at full rate.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: phase_core = CORE_MAX_HZ;
        1: phase_core = CORE_MIN_HZ;
        3: phase_core = KW'(100000000);
        RANDOM_PHASES - 1: phase_core = sdcd_pkg::CORE_RESET_HZ;
        default: phase_core = KW'($urandom_range(1000000, 1000000000));
      endcase
      write_core_clock(phase_core);
      no_idle = (phase == RANDOM_PHASES - 1);
      for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
        req = pick_request(core_hz);
        send_request(req, predict_divider(core_hz, req));
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
